// ===== hdl/named_stopwatch_timer_bank_core_assert.svh =====
// Assertion macros for the stopwatch timer bank
`ifndef NAMED_STOPWATCH_TIMER_BANK_CORE_ASSERT_SVH
`define NAMED_STOPWATCH_TIMER_BANK_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define NSTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent
`define NSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/nstb_pkg.sv =====
// ----------------------------------------------------------------------------
// nstb_pkg
// Shared types and constants of the stopwatch timer bank.
// ----------------------------------------------------------------------------
package nstb_pkg;
    localparam int SLOTS      = 8;
    localparam int KEY_BITS   = 64;
    localparam int COUNT_BITS = 32;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int USED_BITS  = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_PAUSED   = 2'd1,
        MODE_COUNTING = 2'd2,
        MODE_DELETED  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TICK, KIND_START, KIND_PAUSE, KIND_READ,
        KIND_STOP, KIND_STOP_ALL, KIND_DELETE, KIND_DELETE_ALL
    } kind_t;

    typedef enum logic [3:0] {
        ST_NEW, ST_RESTARTED, ST_RESUMED, ST_ALREADY_RUNNING, ST_PAUSED,
        ST_ALREADY_PAUSED, ST_PAUSE_REFUSED, ST_STOPPED, ST_ALREADY_STOPPED,
        ST_READ, ST_DELETED, ST_ALL_STOPPED, ST_ALL_DELETED, ST_NO_SUCH,
        ST_FULL, ST_TICK
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE, FSM_SCAN, FSM_WAIT, FSM_ACT, FSM_WRITE, FSM_OUT
    } fsm_t;

    typedef struct packed {
        mode_t                  mode;
        logic [KEY_BITS-1:0]    key;
        logic [COUNT_BITS-1:0]  count;
    } entry_t;
endpackage

// ===== hdl/named_stopwatch_timer_bank_core.sv =====
// Per command, from input transfer to result valid: one memory read per slot
// during the scan, then read, modify, write back of the hit slot.
// A new command is taken only after the last result has been transferred;
// a stalled result holds off the next input transfer. One item is in flight
// at a time.
// Reset: synchronous, active low; mode bits of every slot are cleared to
// deleted in flops, tick_step returns to 1, the slot use count to zero.
// ----------------------------------------------------------------------------
// named_stopwatch_timer_bank_core
// Pool of named stopwatch slots held in a slot memory.
// ----------------------------------------------------------------------------
`include "named_stopwatch_timer_bank_core_assert.svh"
module named_stopwatch_timer_bank_core
    import nstb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [63:0] s_name_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [2:0]  m_slot_index,
    output logic [31:0] m_elapsed_count
);
    // Mode lives in flops (reset needed, read during the scan); key and count
    // live in the slot memory behind a registered read port.
    logic [KEY_BITS+COUNT_BITS-1:0] mem [SLOTS];
    logic [KEY_BITS+COUNT_BITS-1:0] rd_data_reg;
    mode_t mode_reg [SLOTS];

    fsm_t state_reg, state_next;
    logic [7:0]            tick_step_reg;
    logic [USED_BITS-1:0]  used_reg;
    logic [2:0]            kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [SLOT_BITS:0]    idx_reg;     // scan counter, one bit wider
    logic [SLOT_BITS-1:0]  hit_reg, free_reg;
    logic                  hit_ok_reg, free_ok_reg;
    logic [3:0]            st_reg;
    logic [2:0]            out_slot_reg;
    logic [31:0]           out_count_reg;
    logic                  out_valid_reg;

    // Registered write port
    logic                          we_reg;
    logic [SLOT_BITS-1:0]          wa_reg;
    logic [KEY_BITS+COUNT_BITS-1:0] wd_reg;

    logic [SLOT_BITS-1:0] idx;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 scan_last;
    logic [KEY_BITS-1:0]  rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS:0]  sum;

    // Scan pipeline: flopped scan index and its data-valid flag
    logic [SLOT_BITS-1:0] pidx_reg;
    logic                 pvalid_reg;
    logic                 match;

    assign idx       = idx_reg[SLOT_BITS-1:0];
    assign scan_last = (idx_reg == (SLOT_BITS+1)'(SLOTS - 1));
    assign rd_key    = rd_data_reg[KEY_BITS+COUNT_BITS-1:COUNT_BITS];
    assign rd_count  = rd_data_reg[COUNT_BITS-1:0];
    assign sum       = {1'b0, rd_count} + (COUNT_BITS+1)'(tick_step_reg);
    // In WAIT the last scan datum may still hit: forward its slot number
    assign rd_addr   = (state_reg == FSM_SCAN) ? idx
                     : ((match && !hit_ok_reg) ? pidx_reg : hit_reg);

    assign s_ready         = (state_reg == FSM_IDLE) && !out_valid_reg;
    assign m_valid         = out_valid_reg;
    assign m_status        = st_reg;
    assign m_slot_index    = out_slot_reg;
    assign m_elapsed_count = out_count_reg;

    // Memory: one read, one write per cycle; reads of a deleted slot are
    // masked by its mode bits, so the memory needs no clearing.
    always_ff @(posedge aclk) begin
        if (we_reg) begin
            mem[wa_reg] <= wd_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:  if (s_valid && s_ready) state_next = FSM_SCAN;
            FSM_SCAN:  if (scan_last) state_next = FSM_WAIT;
            FSM_WAIT:  state_next = FSM_ACT;
            FSM_ACT:   state_next = FSM_WRITE;
            FSM_WRITE: state_next = FSM_OUT;
            FSM_OUT:   state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    // Datapath. The scan pipeline: address idx in SCAN, data in the following cycle.
    // Key compare uses the flopped scan index (pidx) in the same scan pass.
    assign match = pvalid_reg && (mode_reg[pidx_reg] != MODE_DELETED) && (rd_key == key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            tick_step_reg <= 8'd1;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            we_reg        <= 1'b0;
            pvalid_reg    <= 1'b0;
            for (int i = 0; i < SLOTS; i++) mode_reg[i] <= MODE_DELETED;
        end else begin
            state_reg  <= state_next;
            we_reg     <= 1'b0;
            pvalid_reg <= (state_reg == FSM_SCAN);
            pidx_reg   <= idx;
            if (cfg_we) tick_step_reg <= cfg_wdata;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;

            // Tick: saturating add per counting slot, written back in the scan
            if (pvalid_reg && kind_reg == KIND_TICK
                    && mode_reg[pidx_reg] == MODE_COUNTING) begin
                we_reg <= 1'b1;
                wa_reg <= pidx_reg;
                wd_reg <= {rd_key, sum[COUNT_BITS] ? {COUNT_BITS{1'b1}}
                                                   : sum[COUNT_BITS-1:0]};
            end
            if (match && !hit_ok_reg) begin
                hit_ok_reg <= 1'b1;
                hit_reg    <= pidx_reg;
            end

            unique case (state_reg)
                FSM_IDLE: begin
                    if (s_valid && s_ready) begin
                        kind_reg    <= s_kind;
                        key_reg     <= s_name_key[KEY_BITS-1:0];
                        idx_reg     <= '0;
                        hit_ok_reg  <= 1'b0;
                        free_ok_reg <= 1'b0;
                        hit_reg     <= '0;
                        free_reg    <= '0;
                    end
                end
                FSM_SCAN: begin
                    if (mode_reg[idx] == MODE_DELETED && !free_ok_reg) begin
                        free_ok_reg <= 1'b1;
                        free_reg    <= idx;
                    end
                    if (!scan_last) idx_reg <= idx_reg + 1'b1;
                end
                FSM_WAIT: begin
                    // Last scan datum is compared here; the hit slot is read here too
                end
                FSM_ACT: begin
                    // rd_data_reg now holds the hit slot (read in WAIT)
                    st_reg        <= ST_TICK;
                    out_slot_reg  <= 3'(hit_reg);
                    out_count_reg <= 32'(rd_count);
                    unique case (kind_t'(kind_reg))
                        KIND_TICK: begin
                            out_slot_reg  <= '0;
                            out_count_reg <= '0;
                        end
                        KIND_START: begin
                            if (hit_ok_reg) begin
                                if (mode_reg[hit_reg] == MODE_COUNTING) begin
                                    st_reg <= ST_ALREADY_RUNNING;
                                end else if (mode_reg[hit_reg] == MODE_PAUSED) begin
                                    st_reg <= ST_RESUMED;
                                    mode_reg[hit_reg] <= MODE_COUNTING;
                                end else begin
                                    st_reg <= ST_RESTARTED;
                                    mode_reg[hit_reg] <= MODE_COUNTING;
                                    out_count_reg <= '0;
                                    we_reg <= 1'b1;
                                    wa_reg <= hit_reg;
                                    wd_reg <= {key_reg, {COUNT_BITS{1'b0}}};
                                end
                            end else if (used_reg >= USED_BITS'(SLOTS) || !free_ok_reg) begin
                                st_reg        <= ST_FULL;
                                out_slot_reg  <= '0;
                                out_count_reg <= '0;
                            end else begin
                                st_reg        <= ST_NEW;
                                out_slot_reg  <= 3'(free_reg);
                                out_count_reg <= '0;
                                mode_reg[free_reg] <= MODE_COUNTING;
                                used_reg <= used_reg + 1'b1;
                                we_reg <= 1'b1;
                                wa_reg <= free_reg;
                                wd_reg <= {key_reg, {COUNT_BITS{1'b0}}};
                            end
                        end
                        KIND_PAUSE, KIND_READ, KIND_STOP, KIND_DELETE: begin
                            if (!hit_ok_reg) begin
                                st_reg        <= ST_NO_SUCH;
                                out_slot_reg  <= '0;
                                out_count_reg <= '0;
                            end else if (kind_reg == KIND_READ) begin
                                st_reg <= ST_READ;
                            end else if (kind_reg == KIND_PAUSE) begin
                                if (mode_reg[hit_reg] == MODE_PAUSED) begin
                                    st_reg <= ST_ALREADY_PAUSED;
                                end else if (mode_reg[hit_reg] == MODE_STOPPED) begin
                                    st_reg <= ST_PAUSE_REFUSED;
                                end else begin
                                    st_reg <= ST_PAUSED;
                                    mode_reg[hit_reg] <= MODE_PAUSED;
                                end
                            end else begin
                                out_count_reg <= '0;
                                we_reg <= 1'b1;
                                wa_reg <= hit_reg;
                                if (kind_reg == KIND_STOP) begin
                                    wd_reg <= {key_reg, {COUNT_BITS{1'b0}}};
                                    st_reg <= (mode_reg[hit_reg] == MODE_STOPPED)
                                              ? ST_ALREADY_STOPPED : ST_STOPPED;
                                    mode_reg[hit_reg] <= MODE_STOPPED;
                                end else begin
                                    wd_reg <= '0;
                                    st_reg <= ST_DELETED;
                                    mode_reg[hit_reg] <= MODE_DELETED;
                                    if (used_reg != '0) used_reg <= used_reg - 1'b1;
                                end
                            end
                        end
                        KIND_STOP_ALL: begin
                            // Counts were cleared slot by slot during the scan
                            st_reg        <= ST_ALL_STOPPED;
                            out_slot_reg  <= '0;
                            out_count_reg <= '0;
                        end
                        default: begin
                            st_reg        <= ST_ALL_DELETED;
                            out_slot_reg  <= '0;
                            out_count_reg <= '0;
                            used_reg      <= '0;
                            for (int i = 0; i < SLOTS; i++) mode_reg[i] <= MODE_DELETED;
                        end
                    endcase
                end
                FSM_WRITE: begin
                    // Write back of the touched slot lands at this edge
                end
                FSM_OUT: begin
                    out_valid_reg <= 1'b1;
                end
                default: begin
                end
            endcase

            // Stop all: zero each live slot during the scan pass
            if (kind_reg == KIND_STOP_ALL && pvalid_reg
                    && mode_reg[pidx_reg] != MODE_DELETED) begin
                mode_reg[pidx_reg] <= MODE_STOPPED;
                we_reg <= 1'b1;
                wa_reg <= pidx_reg;
                wd_reg <= {rd_key, {COUNT_BITS{1'b0}}};
            end
        end
    end

    // Memory read of the hit slot happens in WAIT; when the last slot hits in
    // WAIT its number goes straight to the read address.
    `NSTB_ASSERT_IMP(a_ready_idle, s_ready, state_reg == FSM_IDLE,
        "ready outside idle")
    `NSTB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid,
        "result dropped")
    `NSTB_ASSERT_IMP(a_used_range, 1'b1, used_reg <= USED_BITS'(SLOTS),
        "slot use count overflow")
endmodule
